/* sv/vfm_pkg.sv */
// shared types, constants and corner tables for the voxel face mesher
package vfm_pkg;

    localparam int CHUNK_WIDTH_DEF  = 16;
    localparam int CHUNK_HEIGHT_DEF = 256;

    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);

    localparam int NUM_FACES = 6;
    localparam logic [2:0] VTX_LAST  = 3'd5;
    localparam logic [2:0] ISS_FINAL = 3'd7;

    // corner sequence of the two triangles of one face
    localparam logic [1:0] TRI_ORDER [6] = '{2'd0, 2'd1, 2'd2, 2'd0, 2'd2, 2'd3};

    // one command between front and back
    typedef struct packed {
        logic       mesh;
        logic [3:0] x;
        logic [7:0] y;
        logic [3:0] z;
        logic [7:0] btype;
        logic [5:0] edge_flags;   // face lies on the chunk boundary, face order
    } vfm_cmd_t;

    typedef struct packed {
        logic [4:0] vert_x;
        logic [8:0] vert_y;
        logic [4:0] vert_z;
        logic [2:0] face_dir;
        logic [4:0] tex_u;
        logic [4:0] tex_v;
        logic       last_vertex;
    } vfm_vertex_t;

    // corner offset of a face as {dz, dy, dx}
    function automatic logic [2:0] corner_offset(input logic [2:0] face,
                                                 input logic [1:0] corner);
        logic [11:0] row;
        begin
            case (face)
                3'd0: row = {3'b100, 3'b110, 3'b010, 3'b000};
                3'd1: row = {3'b011, 3'b111, 3'b101, 3'b001};
                3'd2: row = {3'b100, 3'b101, 3'b001, 3'b000};
                3'd3: row = {3'b011, 3'b111, 3'b110, 3'b010};
                3'd4: row = {3'b001, 3'b011, 3'b010, 3'b000};
                3'd5: row = {3'b110, 3'b111, 3'b101, 3'b100};
                default: row = 12'd0;
            endcase
            corner_offset = row[{1'b0, corner, 1'b0} + {2'b00, corner} +: 3];
        end
    endfunction

    // texture corner as {v, u}
    function automatic logic [1:0] corner_uv(input logic [1:0] corner);
        begin
            corner_uv = {corner[1], corner[1] ^ corner[0]};
        end
    endfunction

endpackage

/* sv/vfm_ram.sv */
// generic single write port ram with registered read
module vfm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 65536
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

/* sv/vfm_front.sv */
// input side: takes words, drops out-of-chunk items, marks boundary faces
module vfm_front #(
    parameter int CHUNK_WIDTH  = vfm_pkg::CHUNK_WIDTH_DEF,
    parameter int CHUNK_HEIGHT = vfm_pkg::CHUNK_HEIGHT_DEF
) (
    input  logic             s_tvalid,
    output logic             s_tready,
    input  logic             action,
    input  logic [3:0]       pos_x,
    input  logic [7:0]       pos_y,
    input  logic [3:0]       pos_z,
    input  logic [7:0]       block_type,
    input  logic             clear_done,
    input  logic             q_full,
    output logic             push,
    output vfm_pkg::vfm_cmd_t push_cmd
);

    logic in_chunk;

    assign in_chunk = (32'(pos_x) < 32'(CHUNK_WIDTH)) && (32'(pos_y) < 32'(CHUNK_HEIGHT))
                   && (32'(pos_z) < 32'(CHUNK_WIDTH));

    assign s_tready = clear_done && !q_full;
    // out-of-chunk words are taken and dropped
    assign push     = s_tvalid && s_tready && in_chunk;

    always_comb begin
        push_cmd.mesh          = action;
        push_cmd.x             = pos_x;
        push_cmd.y             = pos_y;
        push_cmd.z             = pos_z;
        push_cmd.btype         = block_type;
        push_cmd.edge_flags[0] = (pos_x == 4'd0);
        push_cmd.edge_flags[1] = (32'(pos_x) == 32'(CHUNK_WIDTH - 1));
        push_cmd.edge_flags[2] = (pos_y == 8'd0);
        push_cmd.edge_flags[3] = (32'(pos_y) == 32'(CHUNK_HEIGHT - 1));
        push_cmd.edge_flags[4] = (pos_z == 4'd0);
        push_cmd.edge_flags[5] = (32'(pos_z) == 32'(CHUNK_WIDTH - 1));
    end

endmodule

/* sv/vfm_queue.sv */
// short command fifo between front and back
module vfm_queue (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              push,
    input  vfm_pkg::vfm_cmd_t push_cmd,
    output logic              full,
    input  logic              pop,
    output vfm_pkg::vfm_cmd_t pop_cmd,
    output logic              empty
);

    vfm_pkg::vfm_cmd_t                entry_reg [vfm_pkg::QUEUE_DEPTH];
    logic [vfm_pkg::QUEUE_PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [vfm_pkg::QUEUE_PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [vfm_pkg::QUEUE_PTR_W:0]    count_reg, count_next;

    assign full    = (count_reg == (vfm_pkg::QUEUE_PTR_W + 1)'(vfm_pkg::QUEUE_DEPTH));
    assign empty   = (count_reg == '0);
    assign pop_cmd = entry_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == vfm_pkg::QUEUE_PTR_W'(vfm_pkg::QUEUE_DEPTH - 1))
                        ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == vfm_pkg::QUEUE_PTR_W'(vfm_pkg::QUEUE_DEPTH - 1))
                        ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

/* sv/vfm_back.sv */
// back end: clears the store, runs writes, reads neighbors and emits vertices
module vfm_back #(
    parameter int CHUNK_WIDTH  = vfm_pkg::CHUNK_WIDTH_DEF,
    parameter int CHUNK_HEIGHT = vfm_pkg::CHUNK_HEIGHT_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    output logic                  clear_done,
    input  logic                  q_empty,
    input  vfm_pkg::vfm_cmd_t     q_cmd,
    output logic                  q_pop,
    output logic                  m_valid,
    input  logic                  m_ready,
    output vfm_pkg::vfm_vertex_t  m_vertex
);

    localparam int DEPTH = CHUNK_WIDTH * CHUNK_WIDTH * CHUNK_HEIGHT;
    localparam int AW    = $clog2(DEPTH);
    localparam logic [AW-1:0] STEP_Z    = AW'(CHUNK_WIDTH);
    localparam logic [AW-1:0] STEP_Y    = AW'(CHUNK_WIDTH * CHUNK_WIDTH);
    localparam logic [AW-1:0] ADDR_LAST = AW'(DEPTH - 1);

    typedef enum logic [3:0] {
        ST_CLEAR = 4'b0001,
        ST_IDLE  = 4'b0010,
        ST_READ  = 4'b0100,
        ST_EMIT  = 4'b1000
    } vfm_state_t;

    vfm_state_t state_reg, state_next;
    logic [AW-1:0] clr_cnt_reg, clr_cnt_next;
    logic [2:0]    iss_cnt_reg, iss_cnt_next;
    logic [2:0]    vtx_reg, vtx_next;
    logic [5:0]    vis_reg, vis_next;
    logic [5:0]    remain_reg, remain_next;
    logic          m_valid_reg, m_valid_next;

    // payload of the voxel being meshed
    logic [AW-1:0] cur_addr_reg, cur_addr_next;
    logic [3:0]    cur_x_reg, cur_x_next;
    logic [7:0]    cur_y_reg, cur_y_next;
    logic [3:0]    cur_z_reg, cur_z_next;
    logic [5:0]    edge_reg, edge_next;
    logic [7:0]    blk_reg, blk_next;
    vfm_pkg::vfm_vertex_t vert_reg, vert_next;

    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    logic [7:0]    ram_wdata;
    logic [AW-1:0] ram_raddr;
    logic [7:0]    ram_rdata;
    logic [AW-1:0] head_addr;

    logic          out_free;
    logic [2:0]    face_sel;
    logic [5:0]    remain_rest;
    logic          last_sel;
    logic [1:0]    corner;
    logic [2:0]    ofs;
    logic [1:0]    uv;

    vfm_ram #(
        .WIDTH (8),
        .DEPTH (DEPTH)
    ) u_store (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign head_addr = AW'(32'(q_cmd.y) * 32'(CHUNK_WIDTH * CHUNK_WIDTH)
                         + 32'(q_cmd.z) * 32'(CHUNK_WIDTH) + 32'(q_cmd.x));

    assign clear_done = (state_reg != ST_CLEAR);
    assign q_pop      = (state_reg == ST_IDLE) && !q_empty;
    assign out_free   = !m_valid_reg || m_ready;

    // lowest face still to emit
    always_comb begin
        face_sel = 3'd0;
        for (int f = vfm_pkg::NUM_FACES - 1; f >= 0; f--) begin
            if (remain_reg[f]) begin
                face_sel = 3'(f);
            end
        end
    end

    assign remain_rest = remain_reg & ~(6'b000001 << face_sel);
    assign last_sel    = (vtx_reg == vfm_pkg::VTX_LAST) && (remain_rest == 6'd0);
    assign corner      = vfm_pkg::TRI_ORDER[vtx_reg];
    assign ofs         = vfm_pkg::corner_offset(face_sel, corner);
    assign uv          = vfm_pkg::corner_uv(corner);

    // voxel and neighbor read address per issue slot
    always_comb begin
        case (iss_cnt_reg)
            3'd0:    ram_raddr = cur_addr_reg;
            3'd1:    ram_raddr = cur_addr_reg - 1'b1;
            3'd2:    ram_raddr = cur_addr_reg + 1'b1;
            3'd3:    ram_raddr = cur_addr_reg - STEP_Y;
            3'd4:    ram_raddr = cur_addr_reg + STEP_Y;
            3'd5:    ram_raddr = cur_addr_reg - STEP_Z;
            3'd6:    ram_raddr = cur_addr_reg + STEP_Z;
            default: ram_raddr = cur_addr_reg;
        endcase
    end

    always_comb begin
        state_next    = state_reg;
        clr_cnt_next  = clr_cnt_reg;
        iss_cnt_next  = iss_cnt_reg;
        vtx_next      = vtx_reg;
        vis_next      = vis_reg;
        remain_next   = remain_reg;
        m_valid_next  = m_valid_reg;
        cur_addr_next = cur_addr_reg;
        cur_x_next    = cur_x_reg;
        cur_y_next    = cur_y_reg;
        cur_z_next    = cur_z_reg;
        edge_next     = edge_reg;
        blk_next      = blk_reg;
        vert_next     = vert_reg;
        ram_we        = 1'b0;
        ram_waddr     = head_addr;
        ram_wdata     = q_cmd.btype;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            ST_CLEAR: begin
                ram_we       = 1'b1;
                ram_waddr    = clr_cnt_reg;
                ram_wdata    = 8'd0;
                clr_cnt_next = clr_cnt_reg + 1'b1;
                if (clr_cnt_reg == ADDR_LAST) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (q_pop) begin
                    if (q_cmd.mesh) begin
                        cur_addr_next = head_addr;
                        cur_x_next    = q_cmd.x;
                        cur_y_next    = q_cmd.y;
                        cur_z_next    = q_cmd.z;
                        edge_next     = q_cmd.edge_flags;
                        iss_cnt_next  = 3'd0;
                        state_next    = ST_READ;
                    end else begin
                        ram_we = 1'b1;
                    end
                end
            end
            ST_READ: begin
                // read data is registered, so it arrives in the cycle after its issue slot
                iss_cnt_next = iss_cnt_reg + 1'b1;
                if (iss_cnt_reg == 3'd1) begin
                    blk_next = ram_rdata;
                end
                for (int f = 0; f < vfm_pkg::NUM_FACES; f++) begin
                    if (iss_cnt_reg == 3'(f + 2)) begin
                        vis_next[f] = edge_reg[f] || (ram_rdata == 8'd0);
                    end
                end
                if (iss_cnt_reg == vfm_pkg::ISS_FINAL) begin
                    vtx_next    = 3'd0;
                    remain_next = vis_next;
                    if ((blk_reg != 8'd0) && (vis_next != 6'd0)) begin
                        state_next = ST_EMIT;
                    end else begin
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_EMIT: begin
                if (out_free) begin
                    m_valid_next          = 1'b1;
                    vert_next.vert_x      = {1'b0, cur_x_reg} + 5'(ofs[0]);
                    vert_next.vert_y      = {1'b0, cur_y_reg} + 9'(ofs[1]);
                    vert_next.vert_z      = {1'b0, cur_z_reg} + 5'(ofs[2]);
                    vert_next.face_dir    = face_sel;
                    vert_next.tex_u       = {1'b0, blk_reg[3:0]} + 5'(uv[0]);
                    vert_next.tex_v       = {1'b0, blk_reg[7:4]} + 5'(uv[1]);
                    vert_next.last_vertex = last_sel;
                    if (vtx_reg == vfm_pkg::VTX_LAST) begin
                        vtx_next    = 3'd0;
                        remain_next = remain_rest;
                        if (remain_rest == 6'd0) begin
                            state_next = ST_IDLE;
                        end
                    end else begin
                        vtx_next = vtx_reg + 1'b1;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_CLEAR;
            clr_cnt_reg <= '0;
            iss_cnt_reg <= 3'd0;
            vtx_reg     <= 3'd0;
            vis_reg     <= 6'd0;
            remain_reg  <= 6'd0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            clr_cnt_reg <= clr_cnt_next;
            iss_cnt_reg <= iss_cnt_next;
            vtx_reg     <= vtx_next;
            vis_reg     <= vis_next;
            remain_reg  <= remain_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        cur_addr_reg <= cur_addr_next;
        cur_x_reg    <= cur_x_next;
        cur_y_reg    <= cur_y_next;
        cur_z_reg    <= cur_z_next;
        edge_reg     <= edge_next;
        blk_reg      <= blk_next;
        vert_reg     <= vert_next;
    end

    assign m_valid  = m_valid_reg;
    assign m_vertex = vert_reg;

    a_no_out_in_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_CLEAR) |-> !m_valid_reg)
        else $error("vertex pending during store clear");

    a_pop_only_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        q_pop |-> (state_reg == ST_IDLE) && !q_empty)
        else $error("queue popped outside idle");

    a_last_ends_voxel: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_EMIT && out_free && last_sel) |=> (state_reg == ST_IDLE))
        else $error("last vertex did not end the voxel");

    a_emit_has_face: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_EMIT) |-> (remain_reg != 6'd0))
        else $error("emitting with no visible face left");

endmodule

/* sv/voxel_face_mesher.sv */
// voxel face mesher top level: stream ports, front, command queue and back end
// flow: a write word passes the command queue and is written when the idle back end pops it;
//   a mesh item passes the queue, then the seven voxel reads, then its vertices go out
// throughput: writes 1 per cycle while the queue has room; a mesh item holds the back end
//   for the seven reads on the single read port, then 1 vertex a cycle while m_tready is high
// reset: the store is swept to air, all CHUNK_WIDTH*CHUNK_WIDTH*CHUNK_HEIGHT entries
//   (65536 by default), with s_tready low until the sweep ends
module voxel_face_mesher #(
    parameter int CHUNK_WIDTH  = vfm_pkg::CHUNK_WIDTH_DEF,
    parameter int CHUNK_HEIGHT = vfm_pkg::CHUNK_HEIGHT_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // pos_x[3:0], pos_y[11:4], pos_z[15:12], block_type[23:16]
    input  logic        s_tuser,   // action: 0 write, 1 mesh
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // vert_x, vert_y, vert_z, face_dir, tex_u, tex_v
    output logic        m_tlast    // last_vertex
);

    logic                 clear_done;
    logic                 q_full;
    logic                 q_empty;
    logic                 push;
    logic                 pop;
    vfm_pkg::vfm_cmd_t    push_cmd;
    vfm_pkg::vfm_cmd_t    pop_cmd;
    vfm_pkg::vfm_vertex_t vertex;

    vfm_front #(
        .CHUNK_WIDTH  (CHUNK_WIDTH),
        .CHUNK_HEIGHT (CHUNK_HEIGHT)
    ) u_front (
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .action     (s_tuser),
        .pos_x      (s_tdata[3:0]),
        .pos_y      (s_tdata[11:4]),
        .pos_z      (s_tdata[15:12]),
        .block_type (s_tdata[23:16]),
        .clear_done (clear_done),
        .q_full     (q_full),
        .push       (push),
        .push_cmd   (push_cmd)
    );

    vfm_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .push_cmd (push_cmd),
        .full     (q_full),
        .pop      (pop),
        .pop_cmd  (pop_cmd),
        .empty    (q_empty)
    );

    vfm_back #(
        .CHUNK_WIDTH  (CHUNK_WIDTH),
        .CHUNK_HEIGHT (CHUNK_HEIGHT)
    ) u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .clear_done (clear_done),
        .q_empty    (q_empty),
        .q_cmd      (pop_cmd),
        .q_pop      (pop),
        .m_valid    (m_tvalid),
        .m_ready    (m_tready),
        .m_vertex   (vertex)
    );

    assign m_tdata = {vertex.tex_v, vertex.tex_u, vertex.face_dir,
                      vertex.vert_z, vertex.vert_y, vertex.vert_x};
    assign m_tlast = vertex.last_vertex;

endmodule
